FILE: src/assert_macros.svh
// Assertion macros for the checker file of the codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("codec assertion failed");

// An antecedent that forces a consequent at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("codec assertion failed");

`endif

FILE: src/mtk2_pkg.sv
// Package with the types, code constants and lookup tables of the MTK-2 codec.
`default_nettype none

package mtk2_pkg;

	localparam int FifoDepth = 4;
	localparam int PtrW      = $clog2(FifoDepth);
	localparam int CntW      = $clog2(FifoDepth + 1);

	typedef logic [PtrW-1:0] ptr_t;
	typedef logic [CntW-1:0] cnt_t;

	typedef enum logic [1:0] {
		ShNone = 2'd0,
		ShLat  = 2'd1,
		ShCyr  = 2'd2,
		ShFig  = 2'd3
	} shift_t;

	localparam logic [4:0] CodeLat = 5'h1F;
	localparam logic [4:0] CodeCyr = 5'h00;
	localparam logic [4:0] CodeFig = 5'h1B;

	typedef struct packed {
		logic [4:0]  code_out;
		logic [15:0] char_out;
		logic        error;
		logic        last;
	} result_t;

	typedef struct packed {
		logic       found;
		shift_t     mode;
		logic [4:0] code;
	} enc_t;

	function automatic logic [4:0] rev5(input logic [4:0] v);
		return {v[0], v[1], v[2], v[3], v[4]};
	endfunction

	function automatic logic [4:0] shift_code(input shift_t m);
		logic [4:0] r;
		unique case (m)
			ShLat:   r = CodeLat;
			ShCyr:   r = CodeCyr;
			ShFig:   r = CodeFig;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Lower-cases Latin and Cyrillic capitals and folds the letters that share a code.
	function automatic logic [15:0] prep_char(input logic [15:0] c);
		logic [15:0] t;
		t = c;
		if (c >= 16'h0041 && c <= 16'h005A) begin
			t = c + 16'd32;
		end else if (c >= 16'h0410 && c <= 16'h042F) begin
			t = c + 16'd32;
		end else if (c == 16'h0401) begin
			t = 16'h0451;
		end
		if (t == 16'h0447) begin
			t = 16'h0034;
		end else if (t == 16'h0451) begin
			t = 16'h0435;
		end else if (t == 16'h044A) begin
			t = 16'h044C;
		end
		return t;
	endfunction

	// Space, CR and LF resolve to the figures set.
	function automatic enc_t enc_lookup(input logic [15:0] c);
		enc_t f;
		case (c)
			16'h0061: f = '{1'b1, ShLat, 5'd3};
			16'h0062: f = '{1'b1, ShLat, 5'd25};
			16'h0063: f = '{1'b1, ShLat, 5'd14};
			16'h0064: f = '{1'b1, ShLat, 5'd9};
			16'h0065: f = '{1'b1, ShLat, 5'd1};
			16'h0066: f = '{1'b1, ShLat, 5'd13};
			16'h0067: f = '{1'b1, ShLat, 5'd26};
			16'h0068: f = '{1'b1, ShLat, 5'd20};
			16'h0069: f = '{1'b1, ShLat, 5'd6};
			16'h006A: f = '{1'b1, ShLat, 5'd11};
			16'h006B: f = '{1'b1, ShLat, 5'd15};
			16'h006C: f = '{1'b1, ShLat, 5'd18};
			16'h006D: f = '{1'b1, ShLat, 5'd28};
			16'h006E: f = '{1'b1, ShLat, 5'd12};
			16'h006F: f = '{1'b1, ShLat, 5'd24};
			16'h0070: f = '{1'b1, ShLat, 5'd22};
			16'h0071: f = '{1'b1, ShLat, 5'd23};
			16'h0072: f = '{1'b1, ShLat, 5'd10};
			16'h0073: f = '{1'b1, ShLat, 5'd5};
			16'h0074: f = '{1'b1, ShLat, 5'd16};
			16'h0075: f = '{1'b1, ShLat, 5'd7};
			16'h0076: f = '{1'b1, ShLat, 5'd30};
			16'h0077: f = '{1'b1, ShLat, 5'd19};
			16'h0078: f = '{1'b1, ShLat, 5'd29};
			16'h0079: f = '{1'b1, ShLat, 5'd21};
			16'h007A: f = '{1'b1, ShLat, 5'd17};
			16'h0430: f = '{1'b1, ShCyr, 5'd3};
			16'h0431: f = '{1'b1, ShCyr, 5'd25};
			16'h0432: f = '{1'b1, ShCyr, 5'd19};
			16'h0433: f = '{1'b1, ShCyr, 5'd26};
			16'h0434: f = '{1'b1, ShCyr, 5'd9};
			16'h0435: f = '{1'b1, ShCyr, 5'd1};
			16'h0436: f = '{1'b1, ShCyr, 5'd30};
			16'h0437: f = '{1'b1, ShCyr, 5'd17};
			16'h0438: f = '{1'b1, ShCyr, 5'd6};
			16'h0439: f = '{1'b1, ShCyr, 5'd11};
			16'h043A: f = '{1'b1, ShCyr, 5'd15};
			16'h043B: f = '{1'b1, ShCyr, 5'd18};
			16'h043C: f = '{1'b1, ShCyr, 5'd28};
			16'h043D: f = '{1'b1, ShCyr, 5'd12};
			16'h043E: f = '{1'b1, ShCyr, 5'd24};
			16'h043F: f = '{1'b1, ShCyr, 5'd22};
			16'h0440: f = '{1'b1, ShCyr, 5'd10};
			16'h0441: f = '{1'b1, ShCyr, 5'd5};
			16'h0442: f = '{1'b1, ShCyr, 5'd16};
			16'h0443: f = '{1'b1, ShCyr, 5'd7};
			16'h0444: f = '{1'b1, ShCyr, 5'd13};
			16'h0445: f = '{1'b1, ShCyr, 5'd20};
			16'h0446: f = '{1'b1, ShCyr, 5'd14};
			16'h044B: f = '{1'b1, ShCyr, 5'd21};
			16'h044C: f = '{1'b1, ShCyr, 5'd29};
			16'h044F: f = '{1'b1, ShCyr, 5'd23};
			16'h000A: f = '{1'b1, ShFig, 5'd2};
			16'h0020: f = '{1'b1, ShFig, 5'd4};
			16'h000D: f = '{1'b1, ShFig, 5'd8};
			16'h0033: f = '{1'b1, ShFig, 5'd1};
			16'h002D: f = '{1'b1, ShFig, 5'd3};
			16'h0060: f = '{1'b1, ShFig, 5'd5};
			16'h0038: f = '{1'b1, ShFig, 5'd6};
			16'h0037: f = '{1'b1, ShFig, 5'd7};
			16'h002A: f = '{1'b1, ShFig, 5'd9};
			16'h0034: f = '{1'b1, ShFig, 5'd10};
			16'h044E: f = '{1'b1, ShFig, 5'd11};
			16'h002C: f = '{1'b1, ShFig, 5'd12};
			16'h044D: f = '{1'b1, ShFig, 5'd13};
			16'h003A: f = '{1'b1, ShFig, 5'd14};
			16'h0028: f = '{1'b1, ShFig, 5'd15};
			16'h0035: f = '{1'b1, ShFig, 5'd16};
			16'h002B: f = '{1'b1, ShFig, 5'd17};
			16'h0029: f = '{1'b1, ShFig, 5'd18};
			16'h0032: f = '{1'b1, ShFig, 5'd19};
			16'h0449: f = '{1'b1, ShFig, 5'd20};
			16'h0036: f = '{1'b1, ShFig, 5'd21};
			16'h0030: f = '{1'b1, ShFig, 5'd22};
			16'h0031: f = '{1'b1, ShFig, 5'd23};
			16'h0039: f = '{1'b1, ShFig, 5'd24};
			16'h003F: f = '{1'b1, ShFig, 5'd25};
			16'h0448: f = '{1'b1, ShFig, 5'd26};
			16'h002E: f = '{1'b1, ShFig, 5'd28};
			16'h002F: f = '{1'b1, ShFig, 5'd29};
			16'h003D: f = '{1'b1, ShFig, 5'd30};
			default:  f = '{1'b0, ShNone, 5'd0};
		endcase
		return f;
	endfunction

	// Character of a code in the given shift; zero where the set has none.
	function automatic logic [15:0] glyph(input logic [4:0] code, input shift_t m);
		logic [15:0] lat;
		logic [15:0] cyr;
		logic [15:0] fig;
		logic [15:0] r;
		case (code)
			5'd1:    begin lat = 16'h0065; cyr = 16'h0435; fig = 16'h0033; end
			5'd2:    begin lat = 16'h000A; cyr = 16'h000A; fig = 16'h000A; end
			5'd3:    begin lat = 16'h0061; cyr = 16'h0430; fig = 16'h002D; end
			5'd4:    begin lat = 16'h0020; cyr = 16'h0020; fig = 16'h0020; end
			5'd5:    begin lat = 16'h0073; cyr = 16'h0441; fig = 16'h0060; end
			5'd6:    begin lat = 16'h0069; cyr = 16'h0438; fig = 16'h0038; end
			5'd7:    begin lat = 16'h0075; cyr = 16'h0443; fig = 16'h0037; end
			5'd8:    begin lat = 16'h000D; cyr = 16'h000D; fig = 16'h000D; end
			5'd9:    begin lat = 16'h0064; cyr = 16'h0434; fig = 16'h002A; end
			5'd10:   begin lat = 16'h0072; cyr = 16'h0440; fig = 16'h0034; end
			5'd11:   begin lat = 16'h006A; cyr = 16'h0439; fig = 16'h044E; end
			5'd12:   begin lat = 16'h006E; cyr = 16'h043D; fig = 16'h002C; end
			5'd13:   begin lat = 16'h0066; cyr = 16'h0444; fig = 16'h044D; end
			5'd14:   begin lat = 16'h0063; cyr = 16'h0446; fig = 16'h003A; end
			5'd15:   begin lat = 16'h006B; cyr = 16'h043A; fig = 16'h0028; end
			5'd16:   begin lat = 16'h0074; cyr = 16'h0442; fig = 16'h0035; end
			5'd17:   begin lat = 16'h007A; cyr = 16'h0437; fig = 16'h002B; end
			5'd18:   begin lat = 16'h006C; cyr = 16'h043B; fig = 16'h0029; end
			5'd19:   begin lat = 16'h0077; cyr = 16'h0432; fig = 16'h0032; end
			5'd20:   begin lat = 16'h0068; cyr = 16'h0445; fig = 16'h0449; end
			5'd21:   begin lat = 16'h0079; cyr = 16'h044B; fig = 16'h0036; end
			5'd22:   begin lat = 16'h0070; cyr = 16'h043F; fig = 16'h0030; end
			5'd23:   begin lat = 16'h0071; cyr = 16'h044F; fig = 16'h0031; end
			5'd24:   begin lat = 16'h006F; cyr = 16'h043E; fig = 16'h0039; end
			5'd25:   begin lat = 16'h0062; cyr = 16'h0431; fig = 16'h003F; end
			5'd26:   begin lat = 16'h0067; cyr = 16'h0433; fig = 16'h0448; end
			5'd28:   begin lat = 16'h006D; cyr = 16'h043C; fig = 16'h002E; end
			5'd29:   begin lat = 16'h0078; cyr = 16'h044C; fig = 16'h002F; end
			5'd30:   begin lat = 16'h0076; cyr = 16'h0436; fig = 16'h003D; end
			default: begin lat = 16'h0000; cyr = 16'h0000; fig = 16'h0000; end
		endcase
		unique case (m)
			ShLat:   r = lat;
			ShCyr:   r = cyr;
			ShFig:   r = fig;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/mtk2_chan_ifs.sv
// Valid/ready channel interfaces for the codec's command and result items.
`default_nettype none

interface mtk2_cmd_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic        start_req;
	logic [15:0] char_in;
	logic [7:0]  code_in;

	modport source (output valid, func, start_req, char_in, code_in, input ready);
	modport sink   (input valid, func, start_req, char_in, code_in, output ready);
endinterface

interface mtk2_res_if;
	logic        valid;
	logic        ready;
	logic [4:0]  code_out;
	logic [15:0] char_out;
	logic        error;
	logic        last;

	modport source (output valid, code_out, char_out, error, last, input ready);
	modport sink   (input valid, code_out, char_out, error, last, output ready);
endinterface

`default_nettype wire

FILE: src/mtk2_telegraph_codec.sv
// MTK-2 telegraph codec: Unicode characters to 5-bit codes and back, with shift tracking.
//
//   channel | dir | handshake      | payload
//   cmd     | in  | valid / ready  | func, start_req, char_in, code_in
//   res     | out | valid / ready  | code_out, char_out, error, last
//   cfg     | in  | cfg_we         | cfg_wdata (msb_first)
//
// An item is taken into the input register, translated in one pass once the queue has
// room for two results, and written into a four-entry result queue that feeds the port.
// The result port sends one result per cycle while res.ready is high; an item yields
// at most one result, or two when an encode also emits a shift code.
// The input register takes a new item whenever the queue holds two results or fewer.
// Reset is asynchronous and clears the shift, the abort flag, msb_first and the queue.
`default_nettype none

module mtk2_telegraph_codec (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	mtk2_cmd_if.sink    cmd,
	mtk2_res_if.source  res
);
	import mtk2_pkg::*;

	logic        msb_first_q;
	shift_t      shift_q;
	logic        aborted_q;

	logic        valid_s1;
	logic        func_s1;
	logic        start_s1;
	logic [15:0] char_s1;
	logic [4:0]  code_s1;

	result_t     fifo_q [FifoDepth];
	ptr_t        wr_ptr_q;
	ptr_t        rd_ptr_q;
	cnt_t        cnt_q;

	logic        proc;
	logic        pop;
	shift_t      eff_shift;
	logic        eff_abort;
	enc_t        enc;
	logic [4:0]  dec_code;
	result_t     r0;
	result_t     r1;
	logic [1:0]  n_push;
	shift_t      shift_nx;
	logic        aborted_nx;

	assign proc      = valid_s1 && (cnt_q <= cnt_t'(FifoDepth - 2));
	assign cmd.ready = !valid_s1 || proc;
	assign pop       = res.valid && res.ready;

	assign res.valid    = (cnt_q != '0);
	assign res.code_out = fifo_q[rd_ptr_q].code_out;
	assign res.char_out = fifo_q[rd_ptr_q].char_out;
	assign res.error    = fifo_q[rd_ptr_q].error;
	assign res.last     = fifo_q[rd_ptr_q].last;

	always_comb begin
		eff_shift  = start_s1 ? ShNone : shift_q;
		eff_abort  = start_s1 ? 1'b0 : aborted_q;
		enc        = enc_lookup(prep_char(char_s1));
		dec_code   = msb_first_q ? rev5(code_s1) : code_s1;
		r0         = '0;
		r1         = '0;
		n_push     = 2'd0;
		shift_nx   = eff_shift;
		aborted_nx = eff_abort;

		if (!eff_abort) begin
			if (!func_s1) begin
				if (enc.found) begin
					if (enc.mode != eff_shift) begin
						shift_nx    = enc.mode;
						r0.code_out = msb_first_q ? rev5(shift_code(enc.mode))
						                          : shift_code(enc.mode);
						r1.code_out = msb_first_q ? rev5(enc.code) : enc.code;
						r1.last     = 1'b1;
						n_push      = 2'd2;
					end else begin
						r0.code_out = msb_first_q ? rev5(enc.code) : enc.code;
						r0.last     = 1'b1;
						n_push      = 2'd1;
					end
				end
			end else begin
				if (dec_code == CodeLat) begin
					shift_nx = ShLat;
				end else if (dec_code == CodeCyr) begin
					shift_nx = ShCyr;
				end else if (dec_code == CodeFig) begin
					shift_nx = ShFig;
				end else if (eff_shift == ShNone) begin
					// A character before any shift ends the string.
					aborted_nx = 1'b1;
					r0.error   = 1'b1;
					r0.last    = 1'b1;
					n_push     = 2'd1;
				end else begin
					r0.char_out = glyph(dec_code, eff_shift);
					r0.last     = 1'b1;
					n_push      = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msb_first_q <= 1'b0;
		end else if (cfg_we) begin
			msb_first_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1  <= cmd.func;
			start_s1 <= cmd.start_req;
			char_s1  <= cmd.char_in;
			code_s1  <= cmd.code_in[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= ShNone;
			aborted_q <= 1'b0;
		end else if (proc) begin
			shift_q   <= shift_nx;
			aborted_q <= aborted_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && (n_push != 2'd0)) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (proc && (n_push == 2'd2)) begin
			fifo_q[ptr_t'(wr_ptr_q + 1'b1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= ptr_t'(wr_ptr_q + ptr_t'(n_push));
			end
			if (pop) begin
				rd_ptr_q <= ptr_t'(rd_ptr_q + 1'b1);
			end
			cnt_q <= cnt_t'(cnt_q + (proc ? cnt_t'(n_push) : cnt_t'(0)) - cnt_t'(pop));
		end
	end

endmodule

`default_nettype wire

FILE: src/mtk2_checker.sv
// Port-level checker for the codec, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mtk2_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [4:0]  res_code_out,
	input wire logic [15:0] res_char_out,
	input wire logic        res_error,
	input wire logic        res_last
);
	import mtk2_pkg::*;

	logic [22:0] res_payload;
	logic        res_no_char;
	logic        err_form_ok;
	logic        shift_form_ok;

	assign res_payload   = {res_code_out, res_char_out, res_error, res_last};
	assign res_no_char   = (res_char_out == 16'h0000);
	assign err_form_ok   = res_last && res_no_char && (res_code_out == 5'd0);
	assign shift_form_ok = !res_error && res_no_char &&
		(res_code_out == CodeLat || res_code_out == CodeCyr || res_code_out == CodeFig);

	// A stalled result keeps its payload.
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_payload))

	// An error result is alone and carries no character or code.
	`ASSERT_ALWAYS(a_err_form, clk, arst_n, !(res_valid && res_error) || err_form_ok)

	// Only a shift code may come ahead of the final result of an item.
	`ASSERT_ALWAYS(a_shift_first, clk, arst_n, !(res_valid && !res_last) || shift_form_ok)

	// The character code that follows a shift code is already queued.
	`ASSERT_NEXT(a_pair_ready, clk, arst_n, res_valid && res_ready && !res_last, res_valid)

endmodule

bind mtk2_telegraph_codec mtk2_checker u_mtk2_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_code_out (res.code_out),
	.res_char_out (res.char_out),
	.res_error    (res.error),
	.res_last     (res.last)
);

`default_nettype wire
